FILE: hw/rtl/smaw_pkg.sv
// Shared constants and types for the sensor moving-average watchdog.
package smaw_pkg;

    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned TIME_W            = 32;
    localparam int unsigned CFG_DATA_W        = 32;
    localparam int unsigned CFG_ADDR_W        = 3;
    localparam int unsigned NUM_READINGS_DEF  = 8;

    localparam logic [TIME_W-1:0] SAMPLE_INTERVAL_RST = 32'd1000;
    localparam logic [TIME_W-1:0] ALIVE_TIMEOUT_RST   = 32'd10000;

    // register index, taken from paddr[2]
    localparam logic REG_SAMPLE_INTERVAL = 1'b0;
    localparam logic REG_ALIVE_TIMEOUT   = 1'b1;

    typedef struct packed {
        logic error_active;
        logic error_flag;
        logic error_was_set;
    } t_flags;

endpackage

FILE: hw/rtl/smaw_if.sv
// Request channel interfaces for step input and step result.
interface smaw_in_if
    import smaw_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [TIME_W-1:0]          time_now;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clear_error;

    modport source (output valid, time_now, sample_valid, sample, clear_error, input ready);
    modport sink   (input valid, time_now, sample_valid, sample, clear_error, output ready);
endinterface

interface smaw_out_if
    import smaw_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] last_reading;
    logic                       error_active;
    logic                       error_flag;
    logic                       error_was_set;

    modport source (output valid, average, last_reading, error_active, error_flag,
                    error_was_set, input ready);
    modport sink   (input valid, average, last_reading, error_active, error_flag,
                    error_was_set, output ready);
endinterface

FILE: hw/rtl/smaw_cfg.sv
// APB register block: sample interval and alive timeout.
module smaw_cfg
    import smaw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [TIME_W-1:0]     o_sample_interval,
    output logic [TIME_W-1:0]     o_alive_timeout
);

    logic [TIME_W-1:0] r_sample_interval;
    logic [TIME_W-1:0] r_alive_timeout;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_interval <= SAMPLE_INTERVAL_RST;
            r_alive_timeout   <= ALIVE_TIMEOUT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SAMPLE_INTERVAL: r_sample_interval <= pwdata;
                REG_ALIVE_TIMEOUT:   r_alive_timeout   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SAMPLE_INTERVAL: prdata = r_sample_interval;
            REG_ALIVE_TIMEOUT:   prdata = r_alive_timeout;
            default:             prdata = '0;
        endcase
    end

    assign o_sample_interval = r_sample_interval;
    assign o_alive_timeout   = r_alive_timeout;

endmodule

FILE: hw/rtl/smaw_ring.sv
// Reading ring memory: one write, one registered read, per-entry valid flags.
module smaw_ring
    import smaw_pkg::*;
#(
    parameter int unsigned DEPTH = NUM_READINGS_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic signed [SAMPLE_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic signed [SAMPLE_W-1:0] o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_hit;
    logic                       same_addr;

    assign same_addr = i_we && (i_waddr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // write-through so a read of the slot being written sees new data
        if (same_addr) begin
            r_rd_data <= i_wdata;
        end else begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_hit <= same_addr | r_valid[i_raddr];
        end
    end

    // never-written entries read as the reset value zero
    assign o_rdata = r_rd_hit ? r_rd_data : '0;

endmodule

FILE: hw/rtl/smaw_mean.sv
// Floored mean of the running total: multiply by a scaled reciprocal of the depth.
module smaw_mean
    import smaw_pkg::*;
#(
    parameter int unsigned NUM_READINGS = NUM_READINGS_DEF,
    parameter int unsigned TW           = SAMPLE_W + $clog2(NUM_READINGS)
)(
    input  logic signed [TW-1:0]       i_total,
    output logic signed [SAMPLE_W-1:0] o_mean
);

    // offset makes the total non-negative; it shifts the quotient by 2^15
    localparam int unsigned OFF_INT = NUM_READINGS * (2 ** (SAMPLE_W - 1));
    localparam int unsigned SH      = TW + $clog2(NUM_READINGS) + 1;
    localparam int unsigned MW      = TW + 2;
    localparam logic [63:0] M64     = ((64'd1 << SH) + 64'(NUM_READINGS) - 64'd1)
                                      / 64'(NUM_READINGS);
    localparam logic [MW-1:0] RECIP = M64[MW-1:0];
    localparam logic [TW-1:0] OFF   = TW'(OFF_INT);

    logic [TW-1:0]    biased;
    logic [TW+MW-1:0] prod;
    logic [TW+MW-1:0] quot;

    assign biased = $unsigned(i_total) + OFF;
    assign prod   = (TW+MW)'(biased) * (TW+MW)'(RECIP);
    assign quot   = prod >> SH;
    assign o_mean = $signed(quot[SAMPLE_W-1:0] ^ {1'b1, {(SAMPLE_W-1){1'b0}}});

endmodule

FILE: hw/rtl/sensor_moving_average_watchdog.sv
// Sensor moving average with alive watchdog: top level.
// Accepts one step request per clock cycle when the result side keeps up; each step
// updates the state and writes the ring in the accept cycle, then passes a stage
// register, then the output register that holds the mean from a reciprocal multiply.
// The ring slot about to be overwritten is read ahead from the ring memory through its
// registered read port, addressed by the next write slot, so consecutive steps
// never wait on the memory. Reset clears the ring through per-entry valid flags, so no
// clearing pass is needed and steps are taken right after reset.
module sensor_moving_average_watchdog
    import smaw_pkg::*;
#(
    parameter int unsigned NUM_READINGS = NUM_READINGS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    smaw_in_if.sink               i_in,
    smaw_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned AW = (NUM_READINGS > 1) ? $clog2(NUM_READINGS) : 1;
    localparam int unsigned TW = SAMPLE_W + $clog2(NUM_READINGS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_READINGS - 1);

    logic [TIME_W-1:0] sample_interval;
    logic [TIME_W-1:0] alive_timeout;

    // step state
    logic [AW-1:0]              r_write_slot, n_write_slot;
    logic signed [TW-1:0]       r_total, n_total;
    logic signed [SAMPLE_W-1:0] r_latched, n_latched;
    logic signed [SAMPLE_W-1:0] r_last, n_last;
    logic [TIME_W-1:0]          r_last_avg, n_last_avg;
    logic [TIME_W-1:0]          r_last_alive, n_last_alive;
    logic [TIME_W-1:0]          r_last_step;
    logic                       r_sticky, n_sticky;

    // stage and output registers
    logic                       r_s1_valid;
    logic signed [TW-1:0]       r_s1_total;
    logic signed [SAMPLE_W-1:0] r_s1_last;
    t_flags                     r_s1_flags, n_flags;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_average;
    logic signed [SAMPLE_W-1:0] r_out_last;
    t_flags                     r_out_flags;

    logic                       out_free, s1_move, accept, do_store, timeout;
    logic [TIME_W-1:0]          avg_elapsed, alive_elapsed;
    logic signed [SAMPLE_W-1:0] ring_old, mean;

    smaw_cfg u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_sample_interval (sample_interval),
        .o_alive_timeout   (alive_timeout)
    );

    smaw_ring #(
        .DEPTH (NUM_READINGS),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (do_store),
        .i_waddr (r_write_slot),
        .i_wdata (n_latched),
        .i_raddr (n_write_slot),
        .o_rdata (ring_old)
    );

    smaw_mean #(
        .NUM_READINGS (NUM_READINGS),
        .TW           (TW)
    ) u_mean (
        .i_total (r_s1_total),
        .o_mean  (mean)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_latched    = i_in.sample_valid ? i_in.sample : r_latched;
        n_last_alive = i_in.sample_valid ? r_last_step : r_last_alive;

        avg_elapsed   = i_in.time_now - r_last_avg;
        alive_elapsed = i_in.time_now - n_last_alive;
        do_store      = accept && (avg_elapsed > sample_interval);
        timeout       = alive_elapsed > alive_timeout;

        n_total      = r_total;
        n_last       = r_last;
        n_last_avg   = r_last_avg;
        n_write_slot = r_write_slot;
        if (do_store) begin
            n_total      = r_total - TW'(ring_old) + TW'(n_latched);
            n_last       = n_latched;
            n_last_avg   = i_in.time_now;
            n_write_slot = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + 1'b1;
        end

        n_sticky              = r_sticky | timeout;
        n_flags.error_active  = timeout;
        n_flags.error_was_set = i_in.clear_error & n_sticky;
        if (i_in.clear_error) begin
            n_sticky = 1'b0;
        end
        n_flags.error_flag = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_total      <= '0;
            r_latched    <= '0;
            r_last       <= '0;
            r_last_avg   <= '0;
            r_last_alive <= '0;
            r_last_step  <= '0;
            r_sticky     <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_write_slot <= n_write_slot;
                r_total      <= n_total;
                r_latched    <= n_latched;
                r_last       <= n_last;
                r_last_avg   <= n_last_avg;
                r_last_alive <= n_last_alive;
                r_last_step  <= i_in.time_now;
                r_sticky     <= n_sticky;
            end
            r_s1_valid <= accept || (r_s1_valid && !out_free);
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_total <= n_total;
            r_s1_last  <= n_last;
            r_s1_flags <= n_flags;
        end
        if (s1_move) begin
            r_out_average <= mean;
            r_out_last    <= r_s1_last;
            r_out_flags   <= r_s1_flags;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.average       = r_out_average;
    assign o_out.last_reading  = r_out_last;
    assign o_out.error_active  = r_out_flags.error_active;
    assign o_out.error_flag    = r_out_flags.error_flag;
    assign o_out.error_was_set = r_out_flags.error_was_set;

endmodule

FILE: dv/tb_top.sv
// Testbench for the sensor moving-average watchdog: directed table, then random phases.
module tb_top;
    import smaw_pkg::*;

    localparam int unsigned RING_DEPTH = NUM_READINGS_DEF;
    localparam int unsigned SPAN_CAP   = 3000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASES     = 6;
    localparam int unsigned PHASE_ITEMS = 190;
    localparam logic [CFG_ADDR_W-1:0] ADDR_INTERVAL = {REG_SAMPLE_INTERVAL, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT  = {REG_ALIVE_TIMEOUT, 2'b00};

    typedef struct packed {
        logic [TIME_W-1:0]          time_now;
        logic                       sample_valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clear_error;
    } step_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] last_reading;
        logic                       error_active;
        logic                       error_flag;
        logic                       error_was_set;
    } filter_out_t;

    typedef struct packed {
        step_t       st;
        logic        typed;
        filter_out_t want;
    } dir_row_t;

    localparam filter_out_t NO_WANT = '0;
    localparam int unsigned DIR_ROWS = 21;

    // rows 0..6 start from reset with the default interval and timeout
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{32'd0,     1'b0, 16'sd0,     1'b0}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
        '{'{32'd1000,  1'b1, 16'sh7FFF,  1'b1}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
        '{'{32'd1001,  1'b0, 16'sd0,     1'b0}, 1'b1,
          '{16'sd4095, 16'sh7FFF, 1'b0, 1'b0, 1'b0}},
        '{'{32'd2002,  1'b1, 16'sh8000,  1'b0}, 1'b1,
          '{-16'sd1, 16'sh8000, 1'b0, 1'b0, 1'b0}},
        '{'{32'd13003, 1'b0, 16'sd0,     1'b0}, 1'b1,
          '{-16'sd4097, 16'sh8000, 1'b1, 1'b1, 1'b0}},
        '{'{32'd13004, 1'b1, 16'sd100,   1'b1}, 1'b1,
          '{-16'sd4097, 16'sh8000, 1'b0, 1'b0, 1'b1}},
        '{'{32'd13004, 1'b0, 16'sd0,     1'b1}, 1'b1,
          '{-16'sd4097, 16'sh8000, 1'b0, 1'b0, 1'b0}},
        '{'{32'd14005, 1'b1, -16'sd1,    1'b0}, 1'b0, NO_WANT},
        '{'{32'd15006, 1'b1, 16'sh7FFF,  1'b0}, 1'b0, NO_WANT},
        '{'{32'd16007, 1'b0, 16'sh1234,  1'b0}, 1'b0, NO_WANT},
        '{'{32'd17008, 1'b1, 16'sh8000,  1'b1}, 1'b0, NO_WANT},
        '{'{32'd18009, 1'b1, 16'sd12345, 1'b0}, 1'b0, NO_WANT},
        '{'{32'd19010, 1'b1, -16'sd1,    1'b0}, 1'b0, NO_WANT},
        '{'{32'd20011, 1'b1, -16'sd2,    1'b0}, 1'b0, NO_WANT},
        '{'{32'hFFFF_FF00, 1'b1, 16'sd0, 1'b0}, 1'b0, NO_WANT},
        '{'{32'h0000_0100, 1'b0, 16'sd0, 1'b0}, 1'b0, NO_WANT},
        '{'{32'h0000_0500, 1'b1, 16'sh7FFF, 1'b1}, 1'b0, NO_WANT},
        '{'{32'h0000_0500, 1'b0, 16'sd0, 1'b1}, 1'b0, NO_WANT},
        '{'{32'h0000_0100, 1'b0, 16'sd0, 1'b0}, 1'b0, NO_WANT},
        '{'{32'd10256, 1'b0, 16'sd0,     1'b0}, 1'b0, NO_WANT},
        '{'{32'd10257, 1'b0, 16'sd0,     1'b0}, 1'b0, NO_WANT}
    };

    logic [TIME_W-1:0] phase_interval [PHASES] = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd7,
                                                   32'd0, 32'd1000};
    logic [TIME_W-1:0] phase_timeout  [PHASES] = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'd40,
                                                   32'd0, 32'd10000};
    int unsigned       phase_valid_pct [PHASES] = '{50, 50, 25, 30, 20, 15};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    smaw_in_if  step_if ();
    smaw_out_if res_if ();

    sensor_moving_average_watchdog dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (step_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // filter state mirror
    logic signed [SAMPLE_W-1:0] ring_entries [RING_DEPTH] = '{default: '0};
    int                         next_slot = 0;
    bit                         any_stored = 1'b0;
    int                         total_sum = 0;
    logic signed [SAMPLE_W-1:0] mean_now = '0;
    logic signed [SAMPLE_W-1:0] held_sample = '0;
    logic [TIME_W-1:0]          avg_mark = '0;
    logic [TIME_W-1:0]          alive_mark = '0;
    logic [TIME_W-1:0]          prev_step_time = '0;
    bit                         sticky_fault = 1'b0;
    bit                         timeout_now = 1'b0;
    logic [TIME_W-1:0]          cfg_interval = SAMPLE_INTERVAL_RST;
    logic [TIME_W-1:0]          cfg_timeout = ALIVE_TIMEOUT_RST;

    filter_out_t       pending_results [$];
    logic [TIME_W-1:0] time_cursor;
    int                error_count = 0;
    bit                calm = 1'b0;
    bit                hold_pending = 1'b0;

    function automatic filter_out_t advance_filter(step_t st);
        filter_out_t       r;
        logic [TIME_W-1:0] since_avg;
        logic [TIME_W-1:0] since_alive;
        r = '0;
        // alive mark goes to the previous step time, not this one
        if (st.sample_valid) begin
            held_sample = st.sample;
            alive_mark  = prev_step_time;
        end
        prev_step_time = st.time_now;
        since_avg = st.time_now - avg_mark;
        if (since_avg > cfg_interval) begin
            total_sum = total_sum - int'(ring_entries[next_slot]) + int'(held_sample);
            ring_entries[next_slot] = held_sample;
            // depth is a power of two: arithmetic shift floors
            mean_now   = SAMPLE_W'(total_sum >>> $clog2(RING_DEPTH));
            next_slot  = (next_slot == RING_DEPTH - 1) ? 0 : next_slot + 1;
            any_stored = 1'b1;
            avg_mark   = st.time_now;
        end
        since_alive = st.time_now - alive_mark;
        timeout_now = (since_alive > cfg_timeout);
        if (timeout_now) sticky_fault = 1'b1;
        if (st.clear_error) begin
            r.error_was_set = sticky_fault;
            sticky_fault    = 1'b0;
        end
        r.average = mean_now;
        if (any_stored) begin
            r.last_reading = ring_entries[(next_slot == 0) ? RING_DEPTH - 1 : next_slot - 1];
        end
        r.error_active = timeout_now;
        r.error_flag   = sticky_fault;
        return r;
    endfunction

    function automatic step_t random_step(int unsigned valid_pct);
        step_t       st;
        int unsigned span;
        span = (cfg_interval > SPAN_CAP) ? SPAN_CAP : cfg_interval;
        if (span < 4) span = 4;
        case ($urandom_range(0, 15))
            0: time_cursor = $urandom;
            1: begin
                // same time stamp again
            end
            2: time_cursor = time_cursor - $urandom_range(1, 50);
            default: time_cursor = time_cursor + $urandom_range(0, 2 * span + 2);
        endcase
        st.time_now     = time_cursor;
        st.sample_valid = ($urandom_range(0, 99) < valid_pct);
        if ($urandom_range(0, 7) == 0) begin
            st.sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
            st.sample = SAMPLE_W'($urandom);
        end
        st.clear_error = ($urandom_range(0, 7) == 0);
        return st;
    endfunction

    task automatic compare_result(filter_out_t want, filter_out_t got);
        if (got.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, got.average);
            error_count++;
        end
        if (got.last_reading !== want.last_reading) begin
            $error("last_reading: expected %0d, got %0d", want.last_reading, got.last_reading);
            error_count++;
        end
        if (got.error_active !== want.error_active) begin
            $error("error_active: expected %0d, got %0d", want.error_active, got.error_active);
            error_count++;
        end
        if (got.error_flag !== want.error_flag) begin
            $error("error_flag: expected %0d, got %0d", want.error_flag, got.error_flag);
            error_count++;
        end
        if (got.error_was_set !== want.error_was_set) begin
            $error("error_was_set: expected %0d, got %0d", want.error_was_set,
                   got.error_was_set);
            error_count++;
        end
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] want);
        logic [CFG_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            $error("prdata at %0d: expected %0d, got %0d", addr, want, got);
            error_count++;
        end
    endtask

    task automatic apply_settings(input logic [TIME_W-1:0] interval,
                                  input logic [TIME_W-1:0] timeout);
        cfg_write(ADDR_INTERVAL, interval);
        cfg_write(ADDR_TIMEOUT, timeout);
        cfg_interval = interval;
        cfg_timeout  = timeout;
        check_register(ADDR_INTERVAL, interval);
        check_register(ADDR_TIMEOUT, timeout);
    endtask

    task automatic offer_step(input step_t st, input logic typed, input filter_out_t want);
        filter_out_t predicted;
        step_if.valid        <= 1'b1;
        step_if.time_now     <= st.time_now;
        step_if.sample_valid <= st.sample_valid;
        step_if.sample       <= st.sample;
        step_if.clear_error  <= st.clear_error;
        do @(posedge i_clk); while (!(step_if.valid && step_if.ready));
        predicted = advance_filter(st);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic pause_sender();
        if (!calm && $urandom_range(0, 3) == 0) begin
            step_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained(input int unsigned tail);
        step_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        step_if.valid        <= 1'b0;
        step_if.time_now     <= '0;
        step_if.sample_valid <= 1'b0;
        step_if.sample       <= '0;
        step_if.clear_error  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_register(ADDR_INTERVAL, SAMPLE_INTERVAL_RST);
        check_register(ADDR_TIMEOUT, ALIVE_TIMEOUT_RST);

        for (int i = 0; i < DIR_ROWS; i++) begin
            offer_step(directed_rows[i].st, directed_rows[i].typed, directed_rows[i].want);
            pause_sender();
        end
        time_cursor = directed_rows[DIR_ROWS - 1].st.time_now;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained(4);
            if (p == 4) begin
                apply_settings($urandom_range(0, SPAN_CAP), $urandom_range(0, 10 * SPAN_CAP));
            end else begin
                apply_settings(phase_interval[p], phase_timeout[p]);
            end
            calm = (p == PHASES - 1);
            // long result-side stall while requests keep coming
            if (p == 2) hold_pending = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                offer_step(random_step(phase_valid_pct[p]), 1'b0, NO_WANT);
                pause_sender();
            end
        end

        wait_drained(8);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : result_ready_gen
        forever begin
            if (hold_pending) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        filter_out_t got;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got = '{res_if.average, res_if.last_reading, res_if.error_active,
                    res_if.error_flag, res_if.error_was_set};
            if (pending_results.size() == 0) begin
                $error("result with no step pending");
                error_count++;
            end else begin
                compare_result(pending_results.pop_front(), got);
            end
        end
    end

    initial begin : watchdog_limit
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
